// ----- sv/lrt_pkg.sv -----
// Package for the LRU recency table: request and result structs, request codes,
// and the command struct that passes from the controller to the datapath.
// No dependencies.
package lrt_pkg;

    localparam int KEY_W          = 32;
    localparam int CAP_W          = 9;
    localparam int OCC_W          = 9;
    localparam int REQ_W          = 3;
    localparam int RESET_CAPACITY = 200;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TOUCH  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic             evicted_valid;
        logic [KEY_W-1:0] evicted_key;
        logic             pin_request;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic match;
        logic scan;
        logic exec;
    } cmd_t;

endpackage

// ----- sv/lrt_ctrl.sv -----
// Controller for the LRU recency table: sequences one request through the
// match, scan and execute steps and owns the output valid flag. Uses lrt_pkg.
module lrt_ctrl
    import lrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MATCH = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_exec_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || !out_stall))
        else $error("result written while the previous one is still held");

    a_accept_starts_match: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MATCH))
        else $error("accepted request did not enter the match step");

endmodule

// ----- sv/lrt_dpath.sv -----
// Datapath for the LRU recency table: the recency stack of keys with one
// comparator per slot, the valid bits, the count and the capacity register.
// Uses lrt_pkg; driven by the command struct from lrt_ctrl.
module lrt_dpath
    import lrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  req_t             in_data,
    input  logic             cfg_write,
    input  logic [CAP_W-1:0] cfg_data,
    output rsp_t             out_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int LOG_N = $clog2(MAX_ENTRIES);
    localparam int RESET_CAP = (RESET_CAPACITY <= MAX_ENTRIES) ? RESET_CAPACITY : MAX_ENTRIES;

    logic [KEY_W-1:0]       key_reg  [MAX_ENTRIES];
    logic [KEY_W-1:0]       key_next [MAX_ENTRIES];
    logic [KEY_W-1:0]       key_dn   [MAX_ENTRIES];
    logic [KEY_W-1:0]       key_up   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CAP_W-1:0]       cap_reg;
    req_t                   req_reg;
    logic [MAX_ENTRIES-1:0] match_reg;
    logic [MAX_ENTRIES-1:0] match_next;
    logic [MAX_ENTRIES-1:0] last_reg;
    logic [MAX_ENTRIES-1:0] suf_reg;
    logic [MAX_ENTRIES-1:0] suf_next;
    logic [MAX_ENTRIES-1:0] pre_reg;
    logic [MAX_ENTRIES-1:0] pre_next;
    logic                   hit_reg;
    logic [KEY_W-1:0]       tail_reg;
    logic [KEY_W-1:0]       tail_next;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic                   key_nz;
    logic                   full;
    logic                   cfg_ok;

    // Neighbor taps of the stack: shifting toward the old end and toward the front.
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_tap
        if (g == 0)
        begin : g_first
            assign key_dn[g] = req_reg.key;
        end
        else
        begin : g_rest
            assign key_dn[g] = key_reg[g-1];
        end
        if (g == MAX_ENTRIES - 1)
        begin : g_last
            assign key_up[g] = key_reg[g];
        end
        else
        begin : g_inner
            assign key_up[g] = key_reg[g+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match_next[i] = valid_reg[i] && (key_reg[i] == req_reg.key);
        end
    end

    always_comb
    begin
        suf_next  = match_reg;
        pre_next  = match_reg;
        tail_next = '0;
        for (int s = 0; s < LOG_N; s++)
        begin
            suf_next = suf_next | (suf_next >> (1 << s));
            pre_next = pre_next | (pre_next << (1 << s));
        end
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            tail_next = tail_next | (last_reg[i] ? key_reg[i] : '0);
        end
    end

    assign key_nz = (req_reg.key != '0);
    assign full   = (CMP_W'(count_reg) >= CMP_W'(cap_reg)) && (count_reg != '0);
    assign cfg_ok = (int'(cfg_data) <= MAX_ENTRIES);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        rsp_next   = '0;
        unique case (req_reg.req_type)
            REQ_INSERT, REQ_TOUCH:
            begin
                if (key_nz && hit_reg)
                begin
                    rsp_next.hit = 1'b1;
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (i == 0 || suf_reg[i])
                        begin
                            key_next[i] = key_dn[i];
                        end
                    end
                end
                else if (key_nz && (req_reg.req_type == REQ_INSERT))
                begin
                    if (cap_reg == '0)
                    begin
                        rsp_next.evicted_valid = 1'b1;
                        rsp_next.evicted_key   = req_reg.key;
                        rsp_next.pin_request   = 1'b1;
                    end
                    else
                    begin
                        key_next = key_dn;
                        if (full)
                        begin
                            rsp_next.evicted_valid = 1'b1;
                            rsp_next.evicted_key   = tail_reg;
                            rsp_next.pin_request   = 1'b1;
                        end
                        else
                        begin
                            valid_next = (valid_reg << 1) | MAX_ENTRIES'(1);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            REQ_ERASE:
            begin
                if (key_nz && hit_reg)
                begin
                    rsp_next.hit = 1'b1;
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (pre_reg[i])
                        begin
                            key_next[i] = key_up[i];
                        end
                    end
                    valid_next = valid_reg >> 1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_REMOVE:
            begin
                if (count_reg != '0)
                begin
                    rsp_next.evicted_valid = 1'b1;
                    rsp_next.evicted_key   = tail_reg;
                    valid_next = valid_reg >> 1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_CLEAR:
            begin
                valid_next = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
        rsp_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
        if (cmd.match)
        begin
            match_reg <= match_next;
            last_reg  <= valid_reg & ~(valid_reg >> 1);
        end
        if (cmd.scan)
        begin
            suf_reg  <= suf_next;
            pre_reg  <= pre_next;
            hit_reg  <= |match_reg;
            tail_reg <= tail_next;
        end
        if (cmd.exec)
        begin
            key_reg <= key_next;
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_W'(RESET_CAP);
        end
        else
        begin
            priority if (cmd.exec)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
            end
            else if (cfg_write && cfg_ok)
            begin
                cap_reg <= cfg_data;
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    valid_reg[i] <= valid_reg[i] && (i < int'(cfg_data));
                end
                if (CMP_W'(count_reg) > CMP_W'(cfg_data))
                begin
                    count_reg <= CNT_W'(cfg_data);
                end
            end
        end
    end

    assign out_data = rsp_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("count disagrees with the valid bits");

    a_valid_is_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_reg >> 1) & ~valid_reg) == '0)
        else $error("valid slots are not contiguous from the front");

    a_count_within_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(cap_reg))
        else $error("more keys held than the capacity allows");

endmodule

// ----- sv/lru_recency_table.sv -----
// Top level of the LRU recency table: joins the controller and the datapath.
// Uses lrt_pkg, lrt_ctrl and lrt_dpath.
// A request is registered when accepted, then passes through the match, scan and execute steps;
// the result is registered in the execute step, which waits while the output is stalled.
// One request is handled at a time: a new one is not accepted until the last one has executed.
// Reset clears the controller, the valid bits and the count, and sets capacity to 200
// (or MAX_ENTRIES if smaller); stored keys are not cleared.
module lru_recency_table
    import lrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output rsp_t             out_data,
    input  logic             cfg_write,
    input  logic [CAP_W-1:0] cfg_data
);

    cmd_t cmd;

    lrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lrt_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
